FILE: hw/rtl/kte_pkg.sv
package kte_pkg;

	localparam int CORDIC_STAGES = 24;

	// CORDIC datapath width, Q2.30 plus headroom
	localparam int COR_W = 34;
	localparam logic signed [COR_W-1:0] CORDIC_GAIN = COR_W'(652032874);

	// quarter split + rotation stages + quadrant fixup
	localparam int COR_LAT = CORDIC_STAGES + 2;

	// long division: 33 quotient bits, one per stage, plus setup and final
	localparam int DIV_STEPS = 33;
	localparam int DIV_LAT = DIV_STEPS + 2;

	// product stage right after the CORDIC outputs
	localparam int MUL_STG = COR_LAT + 2;
	localparam int PIPE_LAT = MUL_STG + DIV_LAT;

	localparam logic [31:0] ATAN_TURNS [32] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
		32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
	};

	typedef struct packed {
		logic signed [31:0] quo;
		logic               sat;
	} div_res_t;

endpackage

FILE: hw/rtl/kte_cordic.sv
module kte_cordic (
	input  logic               clk,
	input  logic               en,
	input  logic        [31:0] ang,
	output logic signed [31:0] cosv,
	output logic signed [31:0] sinv
);

	localparam int N = kte_pkg::CORDIC_STAGES;
	localparam int W = kte_pkg::COR_W;

	logic signed [W-1:0] x_s [N+1];
	logic signed [W-1:0] y_s [N+1];
	logic signed [W-1:0] z_s [N+1];
	logic        [1:0]   q_s [N+1];

	logic [31:0] ang_rnd;
	logic [1:0]  quad;
	logic [31:0] resid;

	// nearest quarter turn; residual wraps into [-1/8, 1/8) turn
	assign ang_rnd = ang + 32'h2000_0000;
	assign quad    = ang_rnd[31:30];
	assign resid   = ang - {quad, 30'd0};

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= kte_pkg::CORDIC_GAIN;
			y_s[0] <= '0;
			z_s[0] <= W'(signed'(resid));
			q_s[0] <= quad;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic signed [W-1:0] dx, dy, at;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		assign at = W'(kte_pkg::ATAN_TURNS[i]);
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][W-1]) begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - at;
				end else begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + at;
				end
				q_s[i+1] <= q_s[i];
			end
		end
	end

	logic signed [31:0] xf, yf;
	assign xf = x_s[N][31:0];
	assign yf = y_s[N][31:0];

	always_ff @(posedge clk) begin
		if (en) begin
			unique case (q_s[N])
				2'd0: begin cosv <= xf;  sinv <= yf;  end
				2'd1: begin cosv <= -yf; sinv <= xf;  end
				2'd2: begin cosv <= -xf; sinv <= -yf; end
				default: begin cosv <= yf; sinv <= -xf; end
			endcase
		end
	end

endmodule

FILE: hw/rtl/kte_div.sv
module kte_div (
	input  logic               clk,
	input  logic               en,
	input  logic signed [63:0] num,
	input  logic        [37:0] den,
	output kte_pkg::div_res_t  res
);

	localparam int S = kte_pkg::DIV_STEPS;

	logic [38:0] rem_s [S+1];
	logic [32:0] lo_s  [S+1];
	logic [32:0] quo_s [S+1];
	logic [37:0] den_s [S+1];
	logic        neg_s [S+1];
	logic        ovf_s [S+1];
	logic        nz_s  [S+1];

	logic [63:0] mag;
	logic [38:0] head;
	assign mag  = num[63] ? 64'(-num) : 64'(num);
	assign head = {8'd0, mag[63:33]};

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= head;
			lo_s[0]  <= mag[32:0];
			quo_s[0] <= '0;
			den_s[0] <= den;
			neg_s[0] <= num[63];
			// also catches a zero divisor
			ovf_s[0] <= head >= {1'b0, den};
			nz_s[0]  <= mag != 64'd0;
		end
	end

	for (genvar j = 0; j < S; j++) begin : g_step
		logic [38:0] rsh;
		logic        ge;
		assign rsh = {rem_s[j][37:0], lo_s[j][S-1-j]};
		assign ge  = rsh >= {1'b0, den_s[j]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= ge ? rsh - {1'b0, den_s[j]} : rsh;
				lo_s[j+1]  <= lo_s[j];
				quo_s[j+1] <= {quo_s[j][31:0], ge};
				den_s[j+1] <= den_s[j];
				neg_s[j+1] <= neg_s[j];
				ovf_s[j+1] <= ovf_s[j];
				nz_s[j+1]  <= nz_s[j];
			end
		end
	end

	kte_pkg::div_res_t fin;
	logic [32:0] qv;
	assign qv = quo_s[S];

	always_comb begin
		fin.quo = '0;
		fin.sat = 1'b0;
		priority if (!nz_s[S]) begin
			fin.quo = '0;
		end else if (ovf_s[S]) begin
			fin.quo = neg_s[S] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
			fin.sat = 1'b1;
		end else if (neg_s[S]) begin
			if (qv > 33'h0_8000_0000) begin
				fin.quo = 32'sh8000_0000;
				fin.sat = 1'b1;
			end else begin
				fin.quo = 32'(-qv);
			end
		end else begin
			if (qv > 33'h0_7FFF_FFFF) begin
				fin.quo = 32'sh7FFF_FFFF;
				fin.sat = 1'b1;
			end else begin
				fin.quo = qv[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res <= fin;
		end
	end

endmodule

FILE: hw/rtl/keplerian_to_equinoctial.sv
// Keplerian to modified equinoctial element converter. One element set is taken per clock
// while no result waits on out_ready, and each produces exactly one result, in order. The
// depth is set by the three rotation-mode CORDIC pipelines (one stage per iteration) followed
// by the 33-stage bit-per-stage divider that forms tan(i/2) times cos/sin of the node. The
// pipeline advances whenever its last stage is empty or its result is taken, so a result
// waiting on out_ready stalls every stage and holds in_ready low; in_ready follows
// out_ready combinationally.
module keplerian_to_equinoctial (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic        [39:0] semimajor_axis,
	input  logic        [31:0] eccentricity,
	input  logic        [31:0] inclination,
	input  logic        [31:0] ascending_node,
	input  logic        [31:0] perigee_argument,
	input  logic        [31:0] anomaly_true,
	output logic               out_valid,
	input  logic               out_ready,
	output logic        [39:0] semilatus_rectum,
	output logic signed [31:0] ecc_vector_f,
	output logic signed [31:0] ecc_vector_g,
	output logic signed [31:0] node_vector_h,
	output logic signed [31:0] node_vector_k,
	output logic        [31:0] true_longitude,
	output logic               saturated
);

	localparam int L = kte_pkg::PIPE_LAT;
	localparam int M = kte_pkg::MUL_STG;

	typedef struct packed {
		logic        [39:0] a;
		logic        [31:0] e;
		logic        [31:0] esq;
		logic        [40:0] hi;
		logic        [32:0] lo;
		logic        [39:0] p;
		logic        [31:0] lon;
		logic signed [64:0] fprod;
		logic signed [64:0] gprod;
		logic signed [31:0] f;
		logic signed [31:0] g;
		logic signed [63:0] hnum;
		logic signed [63:0] knum;
		logic        [37:0] den;
	} side_t;

	logic  v_s [1:L];
	side_t side_s [1:L];
	side_t side_d [2:L];
	side_t side_in;
	logic  en;

	logic [31:0] inc_s1, wsum_s1, node_s1;
	logic signed [31:0] cp, sp, ch, sh, cn, sn;
	kte_pkg::div_res_t hres, kres;

	assign en       = !v_s[L] || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= L; k++) v_s[k] <= 1'b0;
		end else if (en) begin
			v_s[1] <= in_valid;
			for (int k = 2; k <= L; k++) v_s[k] <= v_s[k-1];
		end
	end

	always_comb begin
		side_in     = '0;
		side_in.a   = semimajor_axis;
		side_in.e   = eccentricity;
		side_in.lon = ascending_node + perigee_argument + anomaly_true;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[1] <= side_in;
			wsum_s1 <= perigee_argument + ascending_node;
			node_s1 <= ascending_node;
			inc_s1  <= (inclination > 32'h8000_0000) ? 32'h4000_0000 : {1'b0, inclination[31:1]};
			for (int k = 2; k <= L; k++) side_s[k] <= side_d[k];
		end
	end

	logic [63:0] esq_full;
	logic [32:0] om;
	logic [64:0] lo_full;
	logic signed [64:0] ftrunc, gtrunc;

	assign esq_full = side_s[1].e * side_s[1].e;
	assign om       = 33'h1_0000_0000 - {1'b0, side_s[2].esq};
	assign lo_full  = side_s[2].a[31:0] * om;
	assign ftrunc   = side_s[M].fprod >>> 31;
	assign gtrunc   = side_s[M].gprod >>> 31;

	function automatic logic signed [31:0] clamp32(input logic signed [64:0] v);
		if (v > 65'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (v < -65'sh0_8000_0000) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	always_comb begin
		for (int k = 2; k <= L; k++) side_d[k] = side_s[k-1];
		side_d[2].esq  = esq_full[63:32];
		side_d[3].hi   = side_s[2].a[39:32] * om;
		side_d[3].lo   = lo_full[64:32];
		side_d[4].p    = side_s[3].hi[39:0] + 40'(side_s[3].lo);
		side_d[M].fprod = $signed({1'b0, side_s[M-1].e}) * cp;
		side_d[M].gprod = $signed({1'b0, side_s[M-1].e}) * sp;
		side_d[M].hnum  = sh * cn;
		side_d[M].knum  = sh * sn;
		side_d[M].den   = (ch > 32'sd0) ? {ch, 6'd0} : 38'd0;
		side_d[M+1].f   = clamp32(ftrunc);
		side_d[M+1].g   = clamp32(gtrunc);
	end

	kte_cordic u_cor_w (.clk(clk), .en(en), .ang(wsum_s1), .cosv(cp), .sinv(sp));
	kte_cordic u_cor_i (.clk(clk), .en(en), .ang(inc_s1),  .cosv(ch), .sinv(sh));
	kte_cordic u_cor_n (.clk(clk), .en(en), .ang(node_s1), .cosv(cn), .sinv(sn));

	kte_div u_div_h (.clk(clk), .en(en), .num(side_s[M].hnum), .den(side_s[M].den), .res(hres));
	kte_div u_div_k (.clk(clk), .en(en), .num(side_s[M].knum), .den(side_s[M].den), .res(kres));

	assign out_valid        = v_s[L];
	assign semilatus_rectum = side_s[L].p;
	assign ecc_vector_f     = side_s[L].f;
	assign ecc_vector_g     = side_s[L].g;
	assign true_longitude   = side_s[L].lon;
	assign node_vector_h    = hres.quo;
	assign node_vector_k    = kres.quo;
	assign saturated        = hres.sat | kres.sat;

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> v_s[1])
		else $error("accepted transaction did not enter the pipeline");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!en) |=> ($stable(v_s[1]) && $stable(v_s[L])))
		else $error("pipeline moved during a stall");

	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && saturated) |->
		(node_vector_h == 32'sh7FFF_FFFF || node_vector_h == 32'sh8000_0000 ||
		 node_vector_k == 32'sh7FFF_FFFF || node_vector_k == 32'sh8000_0000))
		else $error("saturated flag without a clipped h or k");

	a_p_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[4] |-> (side_s[4].p <= side_s[4].a))
		else $error("semilatus rectum exceeds semimajor axis");

endmodule

FILE: test/testbench.sv
module testbench;

	typedef struct {
		logic [39:0] axis;
		logic [31:0] ecc;
		logic [31:0] incl;
		logic [31:0] node;
		logic [31:0] peri;
		logic [31:0] anom;
	} kepler_t;

	typedef struct {
		logic [39:0] p;
		logic [31:0] f;
		logic [31:0] g;
		logic [31:0] h;
		logic [31:0] k;
		logic [31:0] lon;
		logic        sat;
	} equi_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [39:0] semimajor_axis;
	logic [31:0] eccentricity, inclination, ascending_node, perigee_argument, anomaly_true;
	logic [39:0] semilatus_rectum;
	logic signed [31:0] ecc_vector_f, ecc_vector_g, node_vector_h, node_vector_k;
	logic [31:0] true_longitude;
	logic saturated;

	kepler_t pending_sets[$];
	equi_t   expected_q[$];
	int      n_mismatch = 0;
	int      send_gap = 0, recv_stall = 0;
	bit      send_burst = 0, recv_burst = 0;

	keplerian_to_equinoctial u_dut (.*);

	// rotation-mode CORDIC on a Q0.32 turn angle, quadrant folded out exactly
	function automatic void cordic_turns(input logic [31:0] ang, output longint c,
			output longint s);
		logic [31:0] q, r;
		longint x, y, z, dx, dy;
		q = ((ang + 32'h2000_0000) >> 30) & 32'd3;
		r = ang - (q << 30);
		z = longint'(int'(r));
		x = longint'(kte_pkg::CORDIC_GAIN);
		y = 0;
		for (int i = 0; i < kte_pkg::CORDIC_STAGES; i++) begin
			dx = y >>> (i & 31);
			dy = x >>> (i & 31);
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(kte_pkg::ATAN_TURNS[i & 31]);
			end else begin
				x += dx; y -= dy; z += longint'(kte_pkg::ATAN_TURNS[i & 31]);
			end
		end
		case (q)
			0: begin c = x;  s = y;  end
			1: begin c = -y; s = x;  end
			2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endfunction

	function automatic longint clip32(input longint v, inout bit clipped);
		if (v > 64'sd2147483647) begin
			clipped = 1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			clipped = 1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// tan(i/2) scaling; a non-positive cosine means the tangent is infinite
	function automatic longint node_term(input longint num, input longint den, inout bit sat);
		if (den <= 0) begin
			if (num == 0)
				return 0;
			sat = 1;
			return (num > 0) ? 64'sd2147483647 : -64'sd2147483648;
		end
		return clip32(num / den, sat);
	endfunction

	function automatic equi_t to_equinoctial(input kepler_t s);
		bit [63:0] axis, e2, one_minus, p;
		longint cp, sp, cn, sn, ch, sh, den, ecc;
		logic [31:0] incl;
		bit sat, dummy;
		equi_t r;
		sat = 0;
		dummy = 0;
		axis = {24'b0, s.axis};
		e2 = ({32'b0, s.ecc} * {32'b0, s.ecc}) >> 32;
		one_minus = 64'h1_0000_0000 - e2;
		if (one_minus == 64'h1_0000_0000)
			p = axis;
		else
			p = (axis >> 32) * one_minus + (((axis & 64'hFFFF_FFFF) * one_minus) >> 32);
		ecc = longint'({32'b0, s.ecc});
		cordic_turns(s.peri + s.node, cp, sp);
		r.f = 32'(clip32((ecc * cp) >>> 31, dummy));
		r.g = 32'(clip32((ecc * sp) >>> 31, dummy));
		incl = (s.incl > 32'h8000_0000) ? 32'h8000_0000 : s.incl;
		cordic_turns(incl >> 1, ch, sh);
		cordic_turns(s.node, cn, sn);
		den = (ch > 0) ? ch * 64 : 0;
		r.h = 32'(node_term(sh * cn, den, sat));
		r.k = 32'(node_term(sh * sn, den, sat));
		r.p = p[39:0];
		r.lon = s.node + s.peri + s.anom;
		r.sat = sat;
		return r;
	endfunction

	function automatic void add_set(logic [39:0] a, logic [31:0] e, logic [31:0] i,
			logic [31:0] n, logic [31:0] w, logic [31:0] nu);
		kepler_t s;
		s = '{a, e, i, n, w, nu};
		pending_sets.push_back(s);
	endfunction

	function automatic int draw_wait(bit burst);
		return burst ? 0 : $urandom_range(0, 12);
	endfunction

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		kepler_t s;
		if (!arst_n) begin
			in_valid <= 0;
			semimajor_axis <= '0;
			eccentricity <= '0;
			inclination <= '0;
			ascending_node <= '0;
			perigee_argument <= '0;
			anomaly_true <= '0;
		end else begin
			if (in_valid && in_ready) begin
				s = '{semimajor_axis, eccentricity, inclination, ascending_node,
					perigee_argument, anomaly_true};
				expected_q.push_back(to_equinoctial(s));
				if ($urandom_range(0, 63) == 0)
					send_burst = !send_burst;
				send_gap = draw_wait(send_burst);
			end
			if (in_valid && !in_ready) begin
				// hold the transaction
			end else if (send_gap > 0) begin
				send_gap--;
				in_valid <= 0;
			end else if (pending_sets.size() > 0) begin
				s = pending_sets.pop_front();
				semimajor_axis <= s.axis;
				eccentricity <= s.ecc;
				inclination <= s.incl;
				ascending_node <= s.node;
				perigee_argument <= s.peri;
				anomaly_true <= s.anom;
				in_valid <= 1;
			end else begin
				in_valid <= 0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		equi_t want;
		if (!arst_n) begin
			out_ready <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("unexpected result transaction p=%h", semilatus_rectum);
				end else begin
					want = expected_q.pop_front();
					if (semilatus_rectum !== want.p || ecc_vector_f !== want.f ||
							ecc_vector_g !== want.g || node_vector_h !== want.h ||
							node_vector_k !== want.k || true_longitude !== want.lon ||
							saturated !== want.sat) begin
						n_mismatch++;
						if (n_mismatch <= 10) begin
							$display("mismatch exp p=%h f=%h g=%h h=%h k=%h L=%h s=%b",
								want.p, want.f, want.g, want.h, want.k, want.lon, want.sat);
							$display("         got p=%h f=%h g=%h h=%h k=%h L=%h s=%b",
								semilatus_rectum, ecc_vector_f, ecc_vector_g,
								node_vector_h, node_vector_k, true_longitude, saturated);
						end
					end
				end
				if ($urandom_range(0, 63) == 0)
					recv_burst = !recv_burst;
				recv_stall = draw_wait(recv_burst);
			end
			if (recv_stall > 0) begin
				recv_stall--;
				out_ready <= 0;
			end else begin
				out_ready <= 1;
			end
		end
	end

	initial begin
		logic [31:0] e, i;
		arst_n = 0;
		// directed: field extremes, quadrant boundaries, inclination at and past half turn
		add_set(40'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		add_set('1, '1, 32'h8000_0000, '1, '1, '1);
		add_set('1, 32'd0, 32'h4000_0000, 32'h4000_0000, 32'd0, 32'h1234_5678);
		add_set('1, 32'h8000_0000, 32'hFFFF_FFFF, 32'h2000_0000, 32'h6000_0000, 32'd1);
		add_set(40'h80_0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd0);
		add_set(40'd6778000, 32'd1, 32'h7FF0_0000, 32'hC000_0000, 32'h4000_0000, 32'hFFFF_FFFF);
		add_set(40'd42164000, 32'h0100_0000, 32'h8000_0001, 32'h1FFF_FFFF, 32'h2000_0000,
			32'd5);
		add_set(40'd1, 32'hFFFF_0000, 32'h2000_0000, 32'h6000_0000, 32'hA000_0000,
			32'h5555_5555);
		add_set(40'hFF_FFFF_FFFF, 32'h0000_FFFF, 32'h7FFF_0000, 32'hE000_0000, 32'h2000_0000,
			32'd0);
		add_set(40'h00_FFFF_FFFF, 32'h4000_0000, 32'h1000_0000, 32'hA000_0000, 32'h6000_0000,
			32'd7);
		add_set(40'h01_0000_0000, 32'hC000_0000, 32'h7FFF_FFFE, 32'h4000_0001, 32'h3FFF_FFFF,
			32'hAAAA_AAAA);
		add_set(40'h55_5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
			32'h8000_0000);
		add_set(40'hAA_AAAA_AAAA, 32'h5555_5555, 32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA,
			32'h7FFF_FFFF);
		add_set(40'd7000000, 32'hFFFF_FFFF, 32'h8000_0000, 32'd0, 32'h8000_0000, 32'h8000_0000);
		add_set(40'd7000000, 32'd0, 32'hFFFF_FFFF, 32'hC000_0000, 32'd0, 32'd0);
		for (int n = 0; n < 640; n++) begin
			case ($urandom_range(0, 3))
				0: e = $urandom_range(0, 4096);
				1: e = 32'hFFFF_FFFF - $urandom_range(0, 4096);
				default: e = $urandom;
			endcase
			case ($urandom_range(0, 5))
				0: i = 32'h8000_0000 - $urandom_range(0, 1 << 20);
				1: i = $urandom;
				2: i = $urandom_range(0, 1 << 16);
				default: i = $urandom_range(0, 32'h8000_0000);
			endcase
			add_set(40'({$urandom, $urandom}), e, i, $urandom, $urandom, $urandom);
		end
		repeat (4) @(posedge clk);
		arst_n <= 1;
		wait (pending_sets.size() == 0);
		@(posedge clk);
		wait (!in_valid);
		wait (expected_q.size() == 0);
		repeat (100) @(posedge clk);
		if (n_mismatch == 0 && expected_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end
endmodule

FILE: files.f
hw/rtl/kte_pkg.sv
hw/rtl/kte_cordic.sv
hw/rtl/kte_div.sv
hw/rtl/keplerian_to_equinoctial.sv
test/testbench.sv
